// ===== rtl/ufk_pkg.sv =====
// Shared types, codes and default sizes for the union-find k-th largest set core.
package ufk_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int ELEM_W           = 10;
  localparam int RANK_W           = 11;
  localparam int SIZE_OUT_W       = 11;
  localparam int OP_W             = 2;
  localparam int IN_TDATA_W       = 32;
  localparam int OUT_TDATA_W      = 16;
  localparam int ADDR_W           = 3;
  localparam int DATA_W           = 32;

  typedef enum logic [OP_W-1:0] {
    OP_UNION = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_A,
    ST_FIND_B,
    ST_SZ_A,
    ST_SZ_B,
    ST_DROP_A,
    ST_DROP_B_RD,
    ST_DROP_B,
    ST_SUM,
    ST_INC_RD,
    ST_INC,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

// ===== rtl/ufk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ufk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/union_find_kth_largest_set_core.sv =====
// Top level of the union-find core with a k-th largest set size query.
//
// Usage: commands arrive on the slave stream. tuser carries the operation
// (union, query, clear), tdata carries the two element indices and the rank.
// Only a query produces a transaction on the master stream, carrying the size
// of the k-th largest set among sets of two or more elements, or 1 when the
// rank is zero or larger than the number of such sets. The APB port holds the
// element_count register, the highest element index a union may name.
//
// The block handles one command at a time and drops tready while it works.
// A union walks both parent chains, one link per cycle, and, unless both
// roots are the same, then goes through the size reads, the histogram
// decrements for both old sizes, the merged sum and the histogram increment.
// A query with a rank in range scans the size histogram downward from
// MAX_ELEMENTS, one entry per cycle through the histogram read port, until the
// running count reaches the rank or the scan reaches size two. A clear, and
// reset, run a clearing pass over the three memories before tready rises
// again. Configuration writes are taken at any time.
// A finished query result waits in the output register while the receiver
// stalls; a later query holds in its result state until that one is taken.
module union_find_kth_largest_set_core #(
  parameter int MAX_ELEMENTS = ufk_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Command stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: first_element [9:0], second_element [19:10], rank_k [30:20], zero [31].
  input  logic [ufk_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: operation [1:0].
  input  logic [ufk_pkg::OP_W-1:0]         s_axis_tuser,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: set_size [10:0], zero [15:11].
  output logic [ufk_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ufk_pkg::ADDR_W-1:0]       paddr,
  input  logic [ufk_pkg::DATA_W-1:0]       pwdata,
  output logic [ufk_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int HA_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int SZ_W  = HA_W;
  localparam int CMP_W = (SZ_W > ufk_pkg::RANK_W) ? SZ_W : ufk_pkg::RANK_W;
  localparam int AW    = CMP_W + 1;

  ufk_pkg::state_t state, state_next;

  logic [ufk_pkg::ELEM_W-1:0]     element_count;
  logic [IDX_W-1:0]               a_reg, a_next, b_reg, b_next;
  logic [ufk_pkg::RANK_W-1:0]     k_reg, k_next;
  logic [IDX_W-1:0]               cur, cur_next, steps, steps_next;
  logic [IDX_W-1:0]               ra, ra_next, rb, rb_next;
  logic [SZ_W-1:0]                sa, sa_next, sb, sb_next, total, total_next;
  logic [AW-1:0]                  seen, seen_next;
  logic [HA_W-1:0]                scan_s, scan_s_next;
  logic [SZ_W-1:0]                msc, msc_next;
  logic [HA_W-1:0]                res, res_next;
  logic [HA_W-1:0]                clr_idx, clr_idx_next;
  logic                           out_valid, out_valid_next;
  logic [ufk_pkg::SIZE_OUT_W-1:0] out_size, out_size_next;

  // Memory ports.
  logic             par_we;
  logic [IDX_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
  logic             sz_we;
  logic [IDX_W-1:0] sz_waddr, sz_raddr;
  logic [SZ_W-1:0]  sz_wdata, sz_rdata;
  logic             hist_we;
  logic [HA_W-1:0]  hist_waddr, hist_raddr;
  logic [SZ_W-1:0]  hist_wdata, hist_rdata;

  // The shared adder: histogram decrements and increments, the merged size
  // and the running sum of the query scan all go through it.
  logic [AW-1:0] alu_a, alu_b, alu_sum;
  assign alu_sum = alu_a + alu_b;

  // Decoded command fields.
  logic                       in_accept;
  ufk_pkg::op_t               in_op;
  logic [ufk_pkg::ELEM_W-1:0] in_first, in_second;
  logic [ufk_pkg::RANK_W-1:0] in_rank;
  logic                       union_ok, query_out_of_range;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_op     = ufk_pkg::op_t'(s_axis_tuser);
  assign in_first  = s_axis_tdata[9:0];
  assign in_second = s_axis_tdata[19:10];
  assign in_rank   = s_axis_tdata[30:20];

  assign union_ok = (in_first <= element_count) && (in_second <= element_count) &&
                    (32'(in_first) < MAX_ELEMENTS) && (32'(in_second) < MAX_ELEMENTS);
  assign query_out_of_range = (in_rank == '0) || (CMP_W'(in_rank) > CMP_W'(msc));

  // Parent walk: data on par_rdata belongs to cur.
  logic             find_stop, find_last, find_done;
  logic [IDX_W-1:0] find_root;
  assign find_stop = (par_rdata == cur) || (32'(par_rdata) >= MAX_ELEMENTS);
  assign find_last = (steps == IDX_W'(MAX_ELEMENTS - 1));
  assign find_done = find_stop || find_last;
  assign find_root = find_stop ? cur : par_rdata;

  logic clear_last, scan_hit, scan_last, out_free;
  assign clear_last = (32'(clr_idx) == MAX_ELEMENTS);
  assign scan_hit   = (alu_sum >= AW'(k_reg));
  assign scan_last  = (scan_s == HA_W'(2));
  assign out_free   = !out_valid || m_axis_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ufk_pkg::ST_CLEAR: begin
        if (clear_last) state_next = ufk_pkg::ST_IDLE;
      end
      ufk_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            ufk_pkg::OP_UNION: begin
              if (union_ok) state_next = ufk_pkg::ST_FIND_A;
            end
            ufk_pkg::OP_QUERY: begin
              state_next = query_out_of_range ? ufk_pkg::ST_RESULT : ufk_pkg::ST_SCAN;
            end
            ufk_pkg::OP_CLEAR: state_next = ufk_pkg::ST_CLEAR;
            default:           state_next = ufk_pkg::ST_IDLE;
          endcase
        end
      end
      ufk_pkg::ST_FIND_A: begin
        if (find_done) state_next = ufk_pkg::ST_FIND_B;
      end
      ufk_pkg::ST_FIND_B: begin
        if (find_done) begin
          state_next = (find_root == ra) ? ufk_pkg::ST_IDLE : ufk_pkg::ST_SZ_A;
        end
      end
      ufk_pkg::ST_SZ_A:      state_next = ufk_pkg::ST_SZ_B;
      ufk_pkg::ST_SZ_B:      state_next = ufk_pkg::ST_DROP_A;
      ufk_pkg::ST_DROP_A:    state_next = ufk_pkg::ST_DROP_B_RD;
      ufk_pkg::ST_DROP_B_RD: state_next = ufk_pkg::ST_DROP_B;
      ufk_pkg::ST_DROP_B:    state_next = ufk_pkg::ST_SUM;
      ufk_pkg::ST_SUM:       state_next = ufk_pkg::ST_INC_RD;
      ufk_pkg::ST_INC_RD:    state_next = ufk_pkg::ST_INC;
      ufk_pkg::ST_INC:       state_next = ufk_pkg::ST_IDLE;
      ufk_pkg::ST_SCAN: begin
        if (scan_hit || scan_last) state_next = ufk_pkg::ST_RESULT;
      end
      ufk_pkg::ST_RESULT: begin
        if (out_free) state_next = ufk_pkg::ST_IDLE;
      end
      default: state_next = ufk_pkg::ST_CLEAR;
    endcase
  end

  // Datapath, memory ports and outputs.
  always_comb begin
    a_next        = a_reg;
    b_next        = b_reg;
    k_next        = k_reg;
    cur_next      = cur;
    steps_next    = steps;
    ra_next       = ra;
    rb_next       = rb;
    sa_next       = sa;
    sb_next       = sb;
    total_next    = total;
    seen_next     = seen;
    scan_s_next   = scan_s;
    msc_next      = msc;
    res_next      = res;
    clr_idx_next  = clr_idx;
    out_size_next = out_size;
    out_valid_next = out_valid && !m_axis_tready;

    par_we     = 1'b0;
    par_waddr  = ra;
    par_wdata  = rb;
    par_raddr  = cur;
    sz_we      = 1'b0;
    sz_waddr   = rb;
    sz_wdata   = total;
    sz_raddr   = ra;
    hist_we    = 1'b0;
    hist_waddr = sa;
    hist_wdata = hist_rdata;
    hist_raddr = sa;
    alu_a      = AW'(hist_rdata);
    alu_b      = '1;

    case (state)
      ufk_pkg::ST_CLEAR: begin
        par_we       = (32'(clr_idx) < MAX_ELEMENTS);
        par_waddr    = IDX_W'(clr_idx);
        par_wdata    = IDX_W'(clr_idx);
        sz_we        = par_we;
        sz_waddr     = IDX_W'(clr_idx);
        sz_wdata     = SZ_W'(1);
        hist_we      = 1'b1;
        hist_waddr   = clr_idx;
        hist_wdata   = '0;
        msc_next     = '0;
        clr_idx_next = clear_last ? '0 : clr_idx + HA_W'(1);
      end
      ufk_pkg::ST_IDLE: begin
        a_next     = IDX_W'(in_first);
        b_next     = IDX_W'(in_second);
        k_next     = in_rank;
        cur_next   = IDX_W'(in_first);
        par_raddr  = IDX_W'(in_first);
        steps_next = '0;
        seen_next  = '0;
        scan_s_next = HA_W'(MAX_ELEMENTS);
        hist_raddr = HA_W'(MAX_ELEMENTS);
        res_next   = HA_W'(1);
        clr_idx_next = '0;
      end
      ufk_pkg::ST_FIND_A: begin
        if (find_done) begin
          ra_next    = find_root;
          cur_next   = b_reg;
          par_raddr  = b_reg;
          steps_next = '0;
        end else begin
          cur_next   = par_rdata;
          par_raddr  = par_rdata;
          steps_next = steps + IDX_W'(1);
        end
      end
      ufk_pkg::ST_FIND_B: begin
        sz_raddr = ra;
        if (find_done) begin
          rb_next = find_root;
        end else begin
          cur_next   = par_rdata;
          par_raddr  = par_rdata;
          steps_next = steps + IDX_W'(1);
        end
      end
      ufk_pkg::ST_SZ_A: begin
        sa_next  = sz_rdata;
        sz_raddr = rb;
      end
      ufk_pkg::ST_SZ_B: begin
        sb_next    = sz_rdata;
        hist_raddr = sa;
      end
      ufk_pkg::ST_DROP_A: begin
        // Size counts only above one, and only while the bucket is non-empty.
        hist_waddr = sa;
        hist_wdata = SZ_W'(alu_sum);
        if ((sa > SZ_W'(1)) && (hist_rdata != '0)) begin
          hist_we = 1'b1;
          if (msc != '0) msc_next = msc - SZ_W'(1);
        end
      end
      ufk_pkg::ST_DROP_B_RD: begin
        hist_raddr = sb;
      end
      ufk_pkg::ST_DROP_B: begin
        hist_waddr = sb;
        hist_wdata = SZ_W'(alu_sum);
        if ((sb > SZ_W'(1)) && (hist_rdata != '0)) begin
          hist_we = 1'b1;
          if (msc != '0) msc_next = msc - SZ_W'(1);
        end
      end
      ufk_pkg::ST_SUM: begin
        alu_a = AW'(sa);
        alu_b = AW'(sb);
        total_next = (alu_sum > AW'(MAX_ELEMENTS)) ? SZ_W'(MAX_ELEMENTS) : SZ_W'(alu_sum);
      end
      ufk_pkg::ST_INC_RD: begin
        hist_raddr = total;
      end
      ufk_pkg::ST_INC: begin
        alu_b      = AW'(1);
        hist_we    = 1'b1;
        hist_waddr = total;
        hist_wdata = SZ_W'(alu_sum);
        msc_next   = msc + SZ_W'(1);
        par_we     = 1'b1;
        par_waddr  = ra;
        par_wdata  = rb;
        sz_we      = 1'b1;
        sz_waddr   = rb;
        sz_wdata   = total;
      end
      ufk_pkg::ST_SCAN: begin
        // Running count of sets from the largest size down to scan_s.
        alu_a     = seen;
        alu_b     = AW'(hist_rdata);
        seen_next = alu_sum;
        if (scan_hit) begin
          res_next = scan_s;
        end else if (scan_last) begin
          res_next = HA_W'(1);
        end else begin
          scan_s_next = scan_s - HA_W'(1);
          hist_raddr  = scan_s - HA_W'(1);
        end
      end
      ufk_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_size_next  = ufk_pkg::SIZE_OUT_W'(res);
        end
      end
      default: begin
        clr_idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ufk_pkg::ST_CLEAR;
      clr_idx       <= '0;
      msc           <= '0;
      out_valid     <= 1'b0;
      element_count <= ufk_pkg::ELEM_W'(1023);
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      msc       <= msc_next;
      out_valid <= out_valid_next;
      if (psel && penable && pwrite && pready && !paddr[2]) begin
        element_count <= pwdata[ufk_pkg::ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    a_reg    <= a_next;
    b_reg    <= b_next;
    k_reg    <= k_next;
    cur      <= cur_next;
    steps    <= steps_next;
    ra       <= ra_next;
    rb       <= rb_next;
    sa       <= sa_next;
    sb       <= sb_next;
    total    <= total_next;
    seen     <= seen_next;
    scan_s   <= scan_s_next;
    res      <= res_next;
    out_size <= out_size_next;
  end

  ufk_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_parent_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  ufk_ram #(.WIDTH(SZ_W), .DEPTH(MAX_ELEMENTS)) u_size_ram (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

  ufk_ram #(.WIDTH(SZ_W), .DEPTH(MAX_ELEMENTS + 1)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign s_axis_tready = (state == ufk_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = ufk_pkg::OUT_TDATA_W'(out_size);
  assign pready        = 1'b1;
  assign prdata        = paddr[2] ? '0 : ufk_pkg::DATA_W'(element_count);

endmodule

// ===== rtl/ufk_checker.sv =====
// Port-level checks for the union-find core, bound to its top level.
module ufk_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [ufk_pkg::OP_W-1:0]        s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ufk_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Reset always starts a clearing pass, so no command is taken right after it.
  a_reset_clears: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("command accepted during the clearing pass after reset");

  // A query always keeps the block busy: tready is low right after it is accepted.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ufk_pkg::OP_QUERY))
      |=> !s_axis_tready)
    else $error("block ready right after accepting a query");

  // A reported set size is never zero.
  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[10:0] != '0))
    else $error("result with zero set size");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind union_find_kth_largest_set_core ufk_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
